>>> rtl/swms_pkg.sv
// Package for the sliding-window median block.
// Holds the parameter defaults, the field widths, the mode codes and the cell control struct.
// It has no dependencies.
package swms_pkg;

    localparam int unsigned MAX_WINDOW_DEF  = 64;
    localparam int unsigned TRACKS_DEF      = 8;
    localparam int unsigned SAMPLE_BITS_DEF = 24;

    localparam int unsigned MODE_W  = 2;
    localparam int unsigned TRACK_W = 3;
    localparam int unsigned CFG_W   = 7;

    localparam logic [MODE_W-1:0] MODE_ADD      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXCHANGE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE     = 2'd3;

    localparam logic [CFG_W-1:0] LIMIT_RESET = 7'd64;

    typedef struct packed {
        logic rd_en;
        logic exec;
        logic is_add;
        logic is_rem;
        logic wr_go;
    } t_cell_ctl;

endpackage

>>> rtl/swms_cell.sv
// One position of the sorted window, for every track.
// Holds that position's samples in a small memory and shifts with its two neighbors.
// It depends on swms_pkg.
module swms_cell #(
    parameter int unsigned TRACKS      = swms_pkg::TRACKS_DEF,
    parameter int unsigned SAMPLE_BITS = swms_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned CNT_W       = $clog2(swms_pkg::MAX_WINDOW_DEF + 1),
    parameter int unsigned TRK_W       = (TRACKS > 1) ? $clog2(TRACKS) : 1,
    parameter int unsigned INDEX       = 0
) (
    input  logic                          i_clk,
    input  swms_pkg::t_cell_ctl           i_ctl,
    input  logic [TRK_W-1:0]              i_rd_addr,
    input  logic [TRK_W-1:0]              i_wr_addr,
    input  logic [CNT_W-1:0]              i_count,
    input  logic signed [SAMPLE_BITS-1:0] i_new_value,
    input  logic signed [SAMPLE_BITS-1:0] i_old_value,
    input  logic signed [SAMPLE_BITS-1:0] i_prev_shift,
    input  logic                          i_prev_le,
    input  logic signed [SAMPLE_BITS-1:0] i_next_q,
    output logic signed [SAMPLE_BITS-1:0] o_q,
    output logic signed [SAMPLE_BITS-1:0] o_shift,
    output logic                          o_le,
    output logic                          o_match,
    output logic signed [SAMPLE_BITS-1:0] o_hold
);
    import swms_pkg::*;

    localparam logic [CNT_W:0] IDX0 = (CNT_W + 1)'(INDEX);
    localparam logic [CNT_W:0] IDX1 = (CNT_W + 1)'(INDEX + 1);
    localparam logic [CNT_W:0] IDX2 = (CNT_W + 1)'(INDEX + 2);
    localparam bit IS_FIRST = (INDEX == 0);

    logic signed [SAMPLE_BITS-1:0] r_mem [TRACKS];
    logic signed [SAMPLE_BITS-1:0] r_q;
    logic signed [SAMPLE_BITS-1:0] r_hold;

    logic [CNT_W:0]                w_cnt;
    logic signed [SAMPLE_BITS-1:0] w_shift;
    logic signed [SAMPLE_BITS-1:0] w_ins;
    logic signed [SAMPLE_BITS-1:0] n_value;
    logic                          w_in_m;
    logic                          w_le;
    logic                          w_in_win;
    logic                          w_we;

    always_comb begin
        w_cnt   = {1'b0, i_count};
        o_match = (IDX0 < w_cnt) && (r_q == i_old_value);
        w_shift = (i_ctl.is_add || (r_q < i_old_value)) ? r_q : i_next_q;
        w_in_m  = i_ctl.is_add ? (IDX0 < w_cnt) : (IDX1 < w_cnt);
        w_le    = w_in_m && (w_shift <= i_new_value);
        priority if (w_le) begin
            w_ins = w_shift;
        end else if (IS_FIRST || i_prev_le) begin
            w_ins = i_new_value;
        end else begin
            w_ins = i_prev_shift;
        end
        n_value = i_ctl.is_rem ? w_shift : w_ins;
        priority if (i_ctl.is_add) begin
            w_in_win = (IDX0 <= w_cnt);
        end else if (i_ctl.is_rem) begin
            w_in_win = (IDX2 <= w_cnt);
        end else begin
            w_in_win = (IDX1 <= w_cnt);
        end
        w_we = i_ctl.wr_go && w_in_win;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
        if (w_we) begin
            r_mem[i_wr_addr] <= n_value;
        end
        if (i_ctl.exec) begin
            r_hold <= w_we ? n_value : r_q;
        end
    end

    assign o_q     = r_q;
    assign o_shift = w_shift;
    assign o_le    = w_le;
    assign o_hold  = r_hold;

endmodule

>>> rtl/sliding_window_median_sorted.sv
// Top level of the sliding-window running median, one sorted window per track.
// Instantiates a row of swms_cell and depends on swms_pkg.
//
// No transaction is accepted during an update or while a result waits for the output. The
// accepting edge reads the named track's entry from every cell's memory, the next cycle updates
// all cells at once through their neighbor links and writes back those in the window unless the
// operation fails, and once the output is free the median is selected into the output register,
// also while the next transaction is read. Configuration writes take effect at once and are meant
// for idle periods. The window count is shared by all tracks and changes only on a frame end.
module sliding_window_median_sorted #(
    parameter int unsigned MAX_WINDOW  = swms_pkg::MAX_WINDOW_DEF,
    parameter int unsigned TRACKS      = swms_pkg::TRACKS_DEF,
    parameter int unsigned SAMPLE_BITS = swms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [swms_pkg::MODE_W-1:0]             i_mode,
    input  logic [swms_pkg::TRACK_W-1:0]            i_track,
    input  logic signed [SAMPLE_BITS-1:0]           i_new_value,
    input  logic signed [SAMPLE_BITS-1:0]           i_old_value,
    input  logic                                    i_frame_end,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [SAMPLE_BITS-1:0]           o_median_value,
    output logic [$clog2(MAX_WINDOW + 1)-1:0]       o_held_count,
    output logic                                    o_op_error,
    input  logic                                    i_cfg_wr_en,
    input  logic [swms_pkg::CFG_W-1:0]              i_cfg_wr_data
);
    import swms_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int unsigned IDX_W = $clog2(MAX_WINDOW);
    localparam int unsigned TRK_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [6:0]  TRACKS_C = 7'(TRACKS);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_WINDOW);

    logic                   r_exec;
    logic                   r_sel;
    logic                   r_out_valid;
    logic [CNT_W-1:0]       r_frames;
    logic [CFG_W-1:0]       r_limit;

    logic [MODE_W-1:0]      r_mode;
    logic                   r_fe;
    logic [TRK_W-1:0]       r_trk;
    logic signed [SAMPLE_BITS-1:0] r_nv;
    logic signed [SAMPLE_BITS-1:0] r_ov;
    logic [CNT_W-1:0]       r_newn;
    logic                   r_err;
    logic signed [SAMPLE_BITS-1:0] r_median;
    logic [CNT_W-1:0]       r_count;
    logic                   r_out_err;

    logic                   w_out_free;
    logic                   w_sel_move;
    logic                   w_accept;
    logic [TRK_W-1:0]       w_trk;
    logic [6:0]             w_trk_full;
    logic                   w_found;
    logic                   w_err;
    logic                   w_go;
    logic [CNT_W-1:0]       n_newn;
    logic [IDX_W-1:0]       w_med_idx;
    t_cell_ctl              w_ctl;

    logic signed [SAMPLE_BITS-1:0] w_q     [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] w_shift [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] w_hold  [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] w_prev_shift [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] w_next_q     [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]  w_le;
    logic [MAX_WINDOW-1:0]  w_prev_le;
    logic [MAX_WINDOW-1:0]  w_match;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_sel_move = r_sel && w_out_free;
    assign o_ready    = !r_exec && (!r_sel || w_out_free);
    assign w_accept   = i_valid && o_ready;

    always_comb begin
        w_trk_full = 7'(i_track);
        for (int k = 0; k < (1 << TRACK_W); k++) begin
            if (w_trk_full >= TRACKS_C) begin
                w_trk_full = w_trk_full - TRACKS_C;
            end
        end
        w_trk = TRK_W'(w_trk_full);
    end

    always_comb begin
        w_found = |w_match;
        unique case (r_mode)
            MODE_ADD: begin
                w_err  = (CMP_W'(r_frames) >= CMP_W'(r_limit)) || (r_frames >= MAX_C);
                n_newn = w_err ? r_frames : r_frames + CNT_W'(1);
            end
            MODE_REMOVE: begin
                w_err  = !w_found;
                n_newn = w_err ? r_frames : r_frames - CNT_W'(1);
            end
            MODE_EXCHANGE: begin
                w_err  = !w_found;
                n_newn = r_frames;
            end
            MODE_NONE: begin
                w_err  = 1'b0;
                n_newn = r_frames;
            end
        endcase
        w_go = !w_err && (r_mode != MODE_NONE);
        w_ctl.rd_en  = w_accept;
        w_ctl.exec   = r_exec;
        w_ctl.is_add = (r_mode == MODE_ADD);
        w_ctl.is_rem = (r_mode == MODE_REMOVE);
        w_ctl.wr_go  = r_exec && w_go;
        w_med_idx    = IDX_W'(r_newn >> 1);
    end

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_prev_shift[g] = '0;
            assign w_prev_le[g]    = 1'b0;
        end else begin : g_mid
            assign w_prev_shift[g] = w_shift[g-1];
            assign w_prev_le[g]    = w_le[g-1];
        end
        if (g == MAX_WINDOW - 1) begin : g_last
            assign w_next_q[g] = w_q[g];
        end else begin : g_inner
            assign w_next_q[g] = w_q[g+1];
        end

        swms_cell #(
            .TRACKS      (TRACKS),
            .SAMPLE_BITS (SAMPLE_BITS),
            .CNT_W       (CNT_W),
            .TRK_W       (TRK_W),
            .INDEX       (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_rd_addr    (w_trk),
            .i_wr_addr    (r_trk),
            .i_count      (r_frames),
            .i_new_value  (r_nv),
            .i_old_value  (r_ov),
            .i_prev_shift (w_prev_shift[g]),
            .i_prev_le    (w_prev_le[g]),
            .i_next_q     (w_next_q[g]),
            .o_q          (w_q[g]),
            .o_shift      (w_shift[g]),
            .o_le         (w_le[g]),
            .o_match      (w_match[g]),
            .o_hold       (w_hold[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exec      <= 1'b0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
            r_frames    <= '0;
            r_limit     <= LIMIT_RESET;
        end else begin
            r_exec <= w_accept;
            if (r_exec) begin
                r_sel <= 1'b1;
            end else if (w_sel_move) begin
                r_sel <= 1'b0;
            end
            if (w_sel_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_exec && r_fe && w_go) begin
                r_frames <= n_newn;
            end
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_mode;
            r_fe   <= i_frame_end;
            r_trk  <= w_trk;
            r_nv   <= i_new_value;
            r_ov   <= i_old_value;
        end
        if (r_exec) begin
            r_newn <= n_newn;
            r_err  <= w_err;
        end
        if (w_sel_move) begin
            r_median  <= (r_newn == '0) ? '0 : w_hold[w_med_idx];
            r_count   <= r_newn;
            r_out_err <= r_err;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_median_value = r_median;
    assign o_held_count   = r_count;
    assign o_op_error     = r_out_err;

    a_exec_to_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exec |=> r_sel)
        else $error("Update cycle was not followed by a pending result.");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_exec && !o_ready))
        else $error("Accepted transaction did not enter the update cycle.");

    a_sel_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sel_move |=> (o_valid && (o_held_count == $past(r_newn))))
        else $error("Pending result did not reach the output register.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frames <= MAX_C)
        else $error("Window count exceeds the window depth.");

endmodule

>>> tb/sliding_window_median_sorted_tb.sv
// Self-checking testbench for sliding_window_median_sorted, the per-track running median.
// Predicts every result from its own copy of the sorted windows and the shared count.
// Depends on swms_pkg and the block itself.
module sliding_window_median_sorted_tb;

    import swms_pkg::*;

    localparam int SAMPLE_W     = SAMPLE_BITS_DEF;
    localparam int WINDOW       = MAX_WINDOW_DEF;
    localparam int TRACK_N      = TRACKS_DEF;
    localparam int COUNT_W      = $clog2(WINDOW + 1);
    localparam int SETTLE_TICKS = 6;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_BURSTS} t_ready_style;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] median;
        logic [COUNT_W-1:0]         count;
        logic                       err;
    } t_median_result;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_valid       = 1'b0;
    logic                       o_ready;
    logic [MODE_W-1:0]          i_mode        = MODE_ADD;
    logic [TRACK_W-1:0]         i_track       = '0;
    logic signed [SAMPLE_W-1:0] i_new_value   = '0;
    logic signed [SAMPLE_W-1:0] i_old_value   = '0;
    logic                       i_frame_end   = 1'b0;
    logic                       o_valid;
    logic                       i_ready       = 1'b0;
    logic signed [SAMPLE_W-1:0] o_median_value;
    logic [COUNT_W-1:0]         o_held_count;
    logic                       o_op_error;
    logic                       i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]           i_cfg_wr_data = '0;

    logic signed [SAMPLE_W-1:0] track_rows [TRACK_N][WINDOW];
    int                         committed_count = 0;
    int                         limit_setting   = int'(LIMIT_RESET);
    t_median_result             expected_medians [$];
    int                         mismatch_count  = 0;
    int                         items_sent      = 0;
    int                         gap_max         = 0;
    int                         burst_left      = 0;
    int                         stall_left      = 0;
    t_ready_style               ready_mode      = READY_RANDOM;

    sliding_window_median_sorted dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_track        (i_track),
        .i_new_value    (i_new_value),
        .i_old_value    (i_old_value),
        .i_frame_end    (i_frame_end),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_median_value (o_median_value),
        .o_held_count   (o_held_count),
        .o_op_error     (o_op_error),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int locate_sample(input logic [TRACK_W-1:0] track, input int len,
                                         input logic signed [SAMPLE_W-1:0] v);
        int i;
        for (i = 0; i < len; i++) begin
            if (track_rows[track][i] == v) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void drop_sample(input logic [TRACK_W-1:0] track, input int len,
                                        input int pos);
        int i;
        for (i = pos; i < len - 1; i++) begin
            track_rows[track][i] = track_rows[track][i + 1];
        end
    endfunction

    function automatic void insert_sample(input logic [TRACK_W-1:0] track, input int len,
                                          input logic signed [SAMPLE_W-1:0] v);
        int pos;
        int i;
        pos = 0;
        while (pos < len && track_rows[track][pos] <= v) begin
            pos++;
        end
        for (i = len; i > pos; i--) begin
            track_rows[track][i] = track_rows[track][i - 1];
        end
        track_rows[track][pos] = v;
    endfunction

    function automatic t_median_result predict_median(input logic [MODE_W-1:0] mode,
                                                      input logic [TRACK_W-1:0] track,
                                                      input logic signed [SAMPLE_W-1:0] new_v,
                                                      input logic signed [SAMPLE_W-1:0] old_v,
                                                      input logic fe);
        t_median_result res;
        int             n;
        int             newn;
        int             pos;
        logic           err;
        n    = committed_count;
        newn = n;
        err  = 1'b0;
        case (mode)
            MODE_ADD: begin
                if (n >= limit_setting || n >= WINDOW) begin
                    err = 1'b1;
                end else begin
                    insert_sample(track, n, new_v);
                    newn = n + 1;
                end
            end
            MODE_REMOVE: begin
                pos = locate_sample(track, n, old_v);
                if (n == 0 || pos < 0) begin
                    err = 1'b1;
                end else begin
                    drop_sample(track, n, pos);
                    newn = n - 1;
                end
            end
            MODE_EXCHANGE: begin
                pos = locate_sample(track, n, old_v);
                if (pos < 0) begin
                    err = 1'b1;
                end else begin
                    drop_sample(track, n, pos);
                    insert_sample(track, n - 1, new_v);
                end
            end
            default: begin
            end
        endcase
        if (fe && !err && mode != MODE_NONE) begin
            committed_count = newn;
        end
        res.median = (newn != 0) ? track_rows[track][newn >> 1] : '0;
        res.count  = newn[COUNT_W-1:0];
        res.err    = err;
        return res;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = SAMPLE_MAX;
            1: v = SAMPLE_MIN;
            2, 3: v = SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] absent_sample(input logic [TRACK_W-1:0] track);
        logic signed [SAMPLE_W-1:0] v;
        do begin
            v = SAMPLE_W'($urandom);
        end while (locate_sample(track, committed_count, v) >= 0);
        return v;
    endfunction

    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [TRACK_W-1:0] track,
                             input logic signed [SAMPLE_W-1:0] new_v,
                             input logic signed [SAMPLE_W-1:0] old_v, input logic fe);
        int gap;
        if (gap_max > 0 && burst_left == 0) begin
            gap = $urandom_range(1, gap_max);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        if (gap_max > 0) begin
            burst_left--;
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_mode      <= mode;
        i_track     <= track;
        i_new_value <= new_v;
        i_old_value <= old_v;
        i_frame_end <= fe;
        do begin
            @(posedge i_clk);
        end while (o_ready !== 1'b1);
        expected_medians.push_back(predict_median(mode, track, new_v, old_v, fe));
        items_sent++;
    endtask

    task automatic wait_results_done();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_medians.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_limit(input int value);
        wait_results_done();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value[CFG_W-1:0];
        limit_setting = value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // A stray transaction never changes a store, so it may sit between frames or,
    // on a track not yet updated, inside one.
    task automatic send_stray_item(input logic [TRACK_W-1:0] track);
        logic fe;
        fe = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: send_item(MODE_NONE, track, random_sample(), random_sample(), fe);
            1: send_item(MODE_EXCHANGE, track, random_sample(), absent_sample(track), fe);
            2: send_item(MODE_REMOVE, track, random_sample(), absent_sample(track), fe);
            default: begin
                if (committed_count >= limit_setting) begin
                    send_item(MODE_ADD, track, random_sample(), random_sample(), fe);
                end else begin
                    send_item(MODE_NONE, track, random_sample(), random_sample(), fe);
                end
            end
        endcase
    endtask

    // Every track takes part in a frame once and with the same mode, so that all
    // stores stay aligned with the shared count.
    task automatic run_frame(input int add_pct);
        int                         order [TRACK_N];
        int                         i;
        int                         j;
        int                         tmp;
        int                         n;
        int                         pick;
        logic [MODE_W-1:0]          mode;
        logic signed [SAMPLE_W-1:0] ov;
        n    = committed_count;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            send_stray_item(TRACK_W'($urandom_range(0, TRACK_N - 1)));
            return;
        end
        if (n >= limit_setting) begin
            mode = (pick < 25) ? MODE_ADD : (pick < 65) ? MODE_REMOVE : MODE_EXCHANGE;
        end else if (n == 0) begin
            mode = (pick < 70) ? MODE_ADD : (pick < 85) ? MODE_REMOVE : MODE_EXCHANGE;
        end else begin
            pick = $urandom_range(0, 99);
            mode = (pick < add_pct) ? MODE_ADD :
                   (pick < add_pct + (100 - add_pct) / 2) ? MODE_REMOVE : MODE_EXCHANGE;
        end
        for (i = 0; i < TRACK_N; i++) begin
            order[i] = i;
        end
        for (i = TRACK_N - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < TRACK_N; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_stray_item(TRACK_W'(order[$urandom_range(i, TRACK_N - 1)]));
            end
            if (mode == MODE_ADD) begin
                ov = random_sample();
            end else if (n > 0 && (mode == MODE_REMOVE || $urandom_range(0, 4) != 0)) begin
                ov = track_rows[order[i]][$urandom_range(0, n - 1)];
            end else begin
                ov = absent_sample(TRACK_W'(order[i]));
            end
            send_item(mode, TRACK_W'(order[i]), random_sample(), ov, i == TRACK_N - 1);
        end
    endtask

    task automatic test_empty_window();
        send_item(MODE_REMOVE, TRACK_W'(0), '0, '0, 1'b1);
        send_item(MODE_EXCHANGE, TRACK_W'(3), SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_item(MODE_NONE, TRACK_W'(7), SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    endtask

    task automatic test_extreme_samples();
        logic signed [SAMPLE_W-1:0] extremes [TRACK_N];
        int                         t;
        extremes[0] = SAMPLE_MAX;
        extremes[1] = SAMPLE_MIN;
        extremes[2] = '0;
        extremes[3] = '1;
        extremes[4] = SAMPLE_W'(1);
        extremes[5] = 24'h555555;
        extremes[6] = 24'hAAAAAA;
        extremes[7] = SAMPLE_MAX;
        for (t = 0; t < TRACK_N; t++) begin
            send_item(MODE_ADD, TRACK_W'(t), extremes[t], ~extremes[t], t == TRACK_N - 1);
        end
        send_item(MODE_EXCHANGE, TRACK_W'(2), SAMPLE_MIN, '0, 1'b0);
        send_item(MODE_EXCHANGE, TRACK_W'(1), SAMPLE_MAX, SAMPLE_W'(123), 1'b1);
        send_item(MODE_REMOVE, TRACK_W'(4), '0, SAMPLE_W'(2), 1'b1);
        send_item(MODE_NONE, TRACK_W'(0), SAMPLE_MIN, SAMPLE_MIN, 1'b1);
    endtask

    task automatic test_full_window();
        write_limit(1);
        send_item(MODE_ADD, TRACK_W'(5), SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    endtask

    task automatic test_random_frames(input int limit, input int count, input int add_pct,
                                      input int gaps, input t_ready_style style);
        int start;
        bit paused;
        write_limit(limit);
        gap_max    = gaps;
        burst_left = 0;
        ready_mode = style;
        start      = items_sent;
        paused     = 1'b0;
        while (items_sent - start < count) begin
            run_frame(add_pct);
            if (!paused && items_sent - start >= count / 2) begin
                wait_results_done();
                paused = 1'b1;
            end
        end
    endtask

    always @(negedge i_clk) begin
        case (ready_mode)
            READY_ALWAYS: i_ready <= 1'b1;
            READY_RANDOM: i_ready <= 1'($urandom_range(0, 1));
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    i_ready <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0) begin
                        stall_left = $urandom_range(1, 12);
                    end
                end
            end
        endcase
    end

    always @(posedge i_clk) begin : check_results
        t_median_result want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (expected_medians.size() == 0) begin
                $display("%0t: unexpected result, expected none, %s %0d count %0d err %0b",
                         $time, "actual median", o_median_value, o_held_count, o_op_error);
                mismatch_count++;
            end else begin
                want = expected_medians.pop_front();
                if (o_median_value !== want.median) begin
                    $display("%0t: median_value expected %0d, actual %0d",
                             $time, $signed(want.median), o_median_value);
                    mismatch_count++;
                end
                if (o_held_count !== want.count) begin
                    $display("%0t: held_count expected %0d, actual %0d",
                             $time, want.count, o_held_count);
                    mismatch_count++;
                end
                if (o_op_error !== want.err) begin
                    $display("%0t: op_error expected %0b, actual %0b",
                             $time, want.err, o_op_error);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        for (int t = 0; t < TRACK_N; t++) begin
            for (int k = 0; k < WINDOW; k++) begin
                track_rows[t][k] = '0;
            end
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_window();
        test_extreme_samples();
        test_full_window();
        test_random_frames(1, 80, 50, 0, READY_ALWAYS);
        test_random_frames(64, 180, 75, 4, READY_RANDOM);
        test_random_frames($urandom_range(2, 63), 120, 50, 6, READY_BURSTS);
        test_random_frames(64, 120, 30, 3, READY_BURSTS);
        wait_results_done();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sliding_window_median_sorted.f
rtl/swms_pkg.sv
rtl/swms_cell.sv
rtl/sliding_window_median_sorted.sv
tb/sliding_window_median_sorted_tb.sv
